// ===== sv/grid_ray_caster_macros.svh =====
`ifndef GRID_RAY_CASTER_MACROS_SVH
`define GRID_RAY_CASTER_MACROS_SVH

// next-cycle implication, off while in reset
`define GRC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

// next-cycle implication, checked through reset as well
`define GRC_ASSERT_ALWAYS(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/grc_pkg.sv =====
`default_nettype none

package grc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAP_WIDTH  = 32;
  localparam int MAP_HEIGHT = 32;
  localparam int TILE_COUNT = 1024;
  localparam int STEP_CAP   = 255;
  localparam int COORD_W    = 24;
  localparam int FAR_W      = 23;
  localparam int TILE_W     = $clog2(TILE_COUNT);
  localparam int STEP_W     = 8;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SNAP_W     = COORD_W + 2;
  localparam int OPND_W     = COORD_W + 3;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int QUO_W      = PROD_W + 1;
  localparam int SUM_W      = QUO_W + 1;
  localparam int REM_W      = DIFF_W + 1;
  localparam int DCNT_W     = $clog2(PROD_W);
  localparam int CELL_W     = SNAP_W - FRAC_BITS;
  localparam int IDX_W      = 2 * CELL_W;
  localparam logic [FAR_W-1:0] FAR_RESET = FAR_W'(655360);

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_CAST  = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic              kind;
    logic [TILE_W-1:0] tile_index;
    logic              tile_solid;
    coord_t            start_x;
    coord_t            start_y;
    coord_t            first_x;
    coord_t            first_y;
  } in_item_t;

  typedef struct packed {
    coord_t hit_x;
    coord_t hit_y;
    logic   wall_hit;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FAR, S_FARW, S_HEAD, S_WY, S_WCMP, S_MRD, S_MCHK,
    S_AMUL, S_ADIV, S_AWAIT, S_BMUL, S_BDIV, S_BWAIT,
    S_DA1, S_DA2, S_DB1, S_DB2, S_SEL, S_COMMIT, S_DONE
  } state_t;

  function automatic logic signed [SNAP_W-1:0] snap_axis(coord_t v, logic pos, logic neg);
    logic signed [SNAP_W-1:0] t;
    t = SNAP_W'(v);
    if (pos) begin
      t = t + SNAP_W'(1 << FRAC_BITS);
      t[FRAC_BITS-1:0] = '0;
    end else if (neg) begin
      t = t - SNAP_W'(1);
      t[FRAC_BITS-1:0] = '0;
    end
    return t;
  endfunction

  function automatic coord_t sat_coord(logic signed [SUM_W-1:0] v);
    logic [SUM_W-COORD_W:0] top;
    top = v[SUM_W-1:COORD_W-1];
    if ((&top) || !(|top)) begin
      return v[COORD_W-1:0];
    end
    return v[SUM_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

endpackage

`default_nettype wire

// ===== sv/grc_div.sv =====
`default_nettype none

module grc_div import grc_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic signed [PROD_W-1:0] num,
  input  wire logic signed [DIFF_W-1:0] den,
  output logic                          done,
  output logic signed [QUO_W-1:0]       quo
);

  logic [PROD_W-1:0] work;
  logic [REM_W-1:0]  rem;
  logic [DIFF_W-1:0] dmag;
  logic [DCNT_W-1:0] cnt;
  logic              neg;
  logic              busy;
  logic [REM_W-1:0]  rem_sh;
  logic              fits;

  assign rem_sh = {rem[REM_W-2:0], work[PROD_W-1]};
  assign fits   = rem_sh >= {1'b0, dmag};
  assign quo    = neg ? -$signed({1'b0, work}) : $signed({1'b0, work});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        work <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
        dmag <= den[DIFF_W-1] ? DIFF_W'(-den) : DIFF_W'(den);
        neg  <= num[PROD_W-1] ^ den[DIFF_W-1];
      end else if (busy) begin
        rem  <= fits ? rem_sh - {1'b0, dmag} : rem_sh;
        work <= {work[PROD_W-2:0], fits};
        cnt  <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/grid_ray_caster.sv =====
// channel   dir  handshake          payload
// in        in   in_valid/in_stall  in_item   (tile write or ray cast)
// out       out  out_valid/out_stall out_item (hit point and wall flag)
// cfg       in   cfg_valid/cfg_ready cfg_data (far limit)
//
// A tile write gives its result the cycle after it is taken. A cast first squares the
// far limit, then per grid step checks the distance and the tile; a step along y only
// needs no division, one along x only one bit-serial division, any other two; at most
// 255 steps. After reset a pass clears all 1024 tiles of the map; in_stall is high.
// One item at a time: in_stall stays high until the result has been taken.
`default_nettype none

module grid_ray_caster import grc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_item,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [FAR_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [FAR_W-1:0]  far_limit;
  logic [TILE_W-1:0] clr_idx;
  logic              tile_mem [TILE_COUNT];
  logic              tile_rd;
  logic              cell_ok;
  logic              hit;
  logic [STEP_W-1:0] n;
  coord_t            sx, sy, x1, y1, x2, y2, ax, ay, bx, by;
  logic signed [PROD_W-1:0] far2, acc, acc2, mul_p;
  logic signed [OPND_W-1:0] mul_a, mul_b;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [SNAP_W-1:0] snapx, snapy, px, py;
  logic signed [CELL_W-1:0] cx, cy;
  logic [IDX_W-1:0]         cell_idx;
  logic                     cell_in;
  logic                     accept;
  logic                     div_start, div_done;
  logic signed [DIFF_W-1:0] div_den;
  logic signed [QUO_W-1:0]  quo;
  logic signed [PROD_W-1:0] walk2;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;

  assign dx    = DIFF_W'(x2) - DIFF_W'(x1);
  assign dy    = DIFF_W'(y2) - DIFF_W'(y1);
  assign snapx = snap_axis(x2, !dx[DIFF_W-1] && (dx != '0), dx[DIFF_W-1]);
  assign snapy = snap_axis(y2, !dy[DIFF_W-1] && (dy != '0), dy[DIFF_W-1]);
  assign px    = SNAP_W'(x2) + (dx[DIFF_W-1] ? -SNAP_W'(1) : SNAP_W'(1));
  assign py    = SNAP_W'(y2) + (dy[DIFF_W-1] ? -SNAP_W'(1) : SNAP_W'(1));
  assign cx    = px[SNAP_W-1:FRAC_BITS];
  assign cy    = py[SNAP_W-1:FRAC_BITS];
  assign cell_idx = IDX_W'($unsigned(cy)) * IDX_W'(MAP_WIDTH) + IDX_W'($unsigned(cx));
  assign cell_in  = !cx[CELL_W-1] && (cx < CELL_W'(MAP_WIDTH))
                 && !cy[CELL_W-1] && (cy < CELL_W'(MAP_HEIGHT))
                 && (cell_idx < IDX_W'(TILE_COUNT));
  assign walk2    = acc + mul_p;
  assign div_start = (state == S_ADIV) || (state == S_BDIV);
  assign div_den   = (state == S_ADIV) ? dx : dy;

  grc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mul_p),
    .den   (div_den),
    .done  (div_done),
    .quo   (quo)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_FAR: begin
        mul_a = OPND_W'(far_limit);
        mul_b = OPND_W'(far_limit);
      end
      S_HEAD: begin
        mul_a = OPND_W'(x1) - OPND_W'(sx);
        mul_b = mul_a;
      end
      S_WY: begin
        mul_a = OPND_W'(y1) - OPND_W'(sy);
        mul_b = mul_a;
      end
      S_AMUL: begin
        mul_a = OPND_W'(dy);
        mul_b = OPND_W'(snapx) - OPND_W'(x1);
      end
      S_BMUL: begin
        mul_a = OPND_W'(dx);
        mul_b = OPND_W'(snapy) - OPND_W'(y1);
      end
      S_DA1: begin
        mul_a = OPND_W'(ax) - OPND_W'(x2);
        mul_b = mul_a;
      end
      S_DA2: begin
        mul_a = OPND_W'(ay) - OPND_W'(y2);
        mul_b = mul_a;
      end
      S_DB1: begin
        mul_a = OPND_W'(bx) - OPND_W'(x2);
        mul_b = mul_a;
      end
      S_DB2: begin
        mul_a = OPND_W'(by) - OPND_W'(y2);
        mul_b = mul_a;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_idx == TILE_W'(TILE_COUNT - 1)) state_next = S_IDLE;
      S_IDLE:   if (accept && in_item.kind == KIND_CAST) state_next = S_FAR;
      S_FAR:    state_next = S_FARW;
      S_FARW:   state_next = S_HEAD;
      S_HEAD:   state_next = (n == STEP_W'(STEP_CAP)) ? S_DONE : S_WY;
      S_WY:     state_next = S_WCMP;
      S_WCMP:   state_next = (walk2 >= far2) ? S_DONE : S_MRD;
      S_MRD:    state_next = S_MCHK;
      S_MCHK: begin
        if (tile_rd && cell_ok) state_next = S_DONE;
        else if (dx != '0)      state_next = S_AMUL;
        else                    state_next = S_COMMIT;
      end
      S_AMUL:   state_next = S_ADIV;
      S_ADIV:   state_next = S_AWAIT;
      S_AWAIT:  if (div_done) state_next = (dy != '0) ? S_BMUL : S_COMMIT;
      S_BMUL:   state_next = S_BDIV;
      S_BDIV:   state_next = S_BWAIT;
      S_BWAIT:  if (div_done) state_next = S_DA1;
      S_DA1:    state_next = S_DA2;
      S_DA2:    state_next = S_DB1;
      S_DB1:    state_next = S_DB2;
      S_DB2:    state_next = S_SEL;
      S_SEL:    state_next = S_COMMIT;
      S_COMMIT: state_next = S_HEAD;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLEAR) begin
      tile_mem[clr_idx] <= 1'b0;
    end else if (accept && in_item.kind == KIND_WRITE) begin
      tile_mem[in_item.tile_index] <= in_item.tile_solid;
    end
    if (state == S_MRD) begin
      tile_rd <= tile_mem[cell_idx[TILE_W-1:0]];
      cell_ok <= cell_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      far_limit <= FAR_RESET;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) far_limit <= cfg_data;
      if (state == S_CLEAR) clr_idx <= clr_idx + TILE_W'(1);
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (accept && in_item.kind == KIND_WRITE) begin
        out_item  <= '0;
        out_valid <= 1'b1;
      end
      if (state == S_DONE) begin
        out_item.hit_x    <= x2;
        out_item.hit_y    <= y2;
        out_item.wall_hit <= hit;
        out_valid         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        sx  <= in_item.start_x;
        sy  <= in_item.start_y;
        x1  <= in_item.start_x;
        y1  <= in_item.start_y;
        x2  <= in_item.first_x;
        y2  <= in_item.first_y;
        n   <= '0;
        hit <= 1'b0;
      end
      S_FARW: far2 <= mul_p;
      S_WY:   acc <= mul_p;
      S_MCHK: begin
        if (tile_rd && cell_ok) hit <= 1'b1;
        ax <= x2;
        ay <= sat_coord(SUM_W'(snapy));
      end
      S_AWAIT: begin
        ax <= sat_coord(SUM_W'(snapx));
        ay <= sat_coord(SUM_W'(y1) + SUM_W'(quo));
      end
      S_BWAIT: begin
        by <= sat_coord(SUM_W'(snapy));
        bx <= sat_coord(SUM_W'(x1) + SUM_W'(quo));
      end
      S_DA2: acc <= mul_p;
      S_DB1: acc <= acc + mul_p;
      S_DB2: acc2 <= mul_p;
      S_SEL: begin
        if (acc2 + mul_p < acc) begin
          ax <= bx;
          ay <= by;
        end
      end
      S_COMMIT: begin
        x1 <= x2;
        y1 <= y2;
        x2 <= ax;
        y2 <= ay;
        n  <= n + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/grc_checker.sv =====
`default_nettype none
`include "grid_ray_caster_macros.svh"

module grc_checker import grc_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  `GRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
  `GRC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_item), "stalled result changed")
  `GRC_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while busy")
  `GRC_ASSERT_ALWAYS(a_clear_after_rst, rst, in_stall, "request taken during map clear")

endmodule

bind grid_ray_caster grc_checker u_grc_checker (.*);

`default_nettype wire
